### hw/rtl/distance_vector_router_unit_assert.svh
// Assertion macros shared by the distance-vector router RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef DISTANCE_VECTOR_ROUTER_UNIT_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTER_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DVR_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define DVR_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

### hw/rtl/dvr_pkg.sv
// Shared types, codes and helpers for the distance-vector router.
// No dependencies; imported by the router top, controller and datapath.
package dvr_pkg;

   localparam int NODE_W = 5;
   localparam int DIST_W = 8;
   localparam int GATE_W = 3;
   localparam int HOP_W  = 8;

   localparam logic [1:0] CMD_ADVERTISE = 2'd0;
   localparam logic [1:0] CMD_ENTRY     = 2'd1;
   localparam logic [1:0] CMD_PACKET    = 2'd2;

   localparam logic [1:0] KIND_TABLE   = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_FORWARD = 2'd2;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0]        command;
      logic [NODE_W-1:0] node;
      logic [DIST_W-1:0] distance;
      logic [GATE_W-1:0] arrival_gate;
      logic              last;
      logic [HOP_W-1:0]  hop_count;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [GATE_W-1:0] gate;
      logic [NODE_W-1:0] out_node;
      logic [DIST_W-1:0] out_distance;
      logic [HOP_W-1:0]  out_hop_count;
      logic              end_of_table;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_PACKET,
      ST_WALK_SCAN,
      ST_WALK_EMIT,
      ST_WALK_SELF
   } state_type;

   typedef struct packed {
      logic capture;
      logic entry_commit;
      logic pkt_load;
      logic walk_read;
      logic walk_step;
      logic walk_load;
      logic self_load;
   } ctrl_type;

   typedef struct packed {
      logic entry_adv;
      logic scan_hit;
      logic scan_more;
      logic extra_self;
      logic out_free;
   } status_type;

   // Add one, saturating at the top of the 8-bit range.
   function automatic logic [7:0] sat_inc(input logic [7:0] value);
      logic [7:0] result;
      if (value == COUNT_MAX) begin
         result = COUNT_MAX;
      end else begin
         result = value + 8'd1;
      end
      return result;
   endfunction

endpackage

### hw/rtl/dvr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the router's distance and gate table.
module dvr_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dvr_datapath.sv
// Router datapath: item latch, known bits, route RAM, walk index, result register.
// Depends on dvr_pkg, dvr_ram and the assertion macro header.
`include "distance_vector_router_unit_assert.svh"

module dvr_datapath import dvr_pkg::*; #(
   parameter int NODES = 32,
   parameter int GATES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic              csr_valid,
   input  logic [NODE_W-1:0] csr_data,
   input  ctrl_type          ctl,
   output status_type        stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   localparam int DEPTH = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int RAM_W = DIST_W + GATE_W;

   req_type           req_ff, req_in;
   logic [NODE_W-1:0] self_ff, self_in;
   logic [DEPTH-1:0]  known_ff, known_in;
   logic              changed_ff, changed_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  node_idx;
   logic              node_in_range;
   logic              self_in_range;
   logic              gate_ok;
   logic              known_hit;
   logic              entry_ok;
   logic              upd;
   logic [DIST_W-1:0] new_dist;
   logic [DEPTH-1:0]  present;
   logic [DEPTH-1:0]  above;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [RAM_W-1:0]  ram_wr_data;
   logic [RAM_W-1:0]  ram_rd_data;
   logic [DIST_W-1:0] ram_dist;
   logic [GATE_W-1:0] ram_gate;

   dvr_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (node_idx),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_dist = ram_rd_data[RAM_W-1:GATE_W];
   assign ram_gate = ram_rd_data[GATE_W-1:0];

   // Entry and packet decode on the latched word; RAM data belongs to it.
   always_comb begin
      node_idx      = req_ff.node[IDX_W-1:0];
      node_in_range = 32'(req_ff.node) < NODES;
      self_in_range = 32'(self_ff) < NODES;
      gate_ok       = 32'(req_ff.arrival_gate) < GATES;
      known_hit     = node_in_range && known_ff[node_idx];
      new_dist      = sat_inc(req_ff.distance);
      entry_ok      = node_in_range && gate_ok && (req_ff.node != self_ff);
      upd           = entry_ok && (!known_hit || (new_dist < ram_dist));
   end

   // Table walk: entries to advertise and whether any lie beyond the index.
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         present[j] = known_ff[j] || (self_in_range && (self_ff == NODE_W'(j)));
         above[j]   = present[j] && (IDX_W'(j) > idx_ff);
      end
   end

   assign ram_wr_en   = ctl.entry_commit && upd;
   assign ram_wr_data = {new_dist, req_ff.arrival_gate};
   assign ram_rd_en   = ctl.capture || ctl.walk_read;
   assign ram_rd_addr = ctl.capture ? req_data.node[IDX_W-1:0] : idx_ff;

   assign stat.entry_adv  = req_ff.last && (changed_ff || upd);
   assign stat.scan_hit   = present[idx_ff];
   assign stat.scan_more  = |above;
   assign stat.extra_self = !self_in_range;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_in       = ctl.capture ? req_data : req_ff;
      self_in      = csr_valid ? csr_data : self_ff;
      known_in     = known_ff;
      changed_in   = changed_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (ram_wr_en) begin
         known_in[node_idx] = 1'b1;
      end
      if (ctl.entry_commit) begin
         changed_in = stat.entry_adv ? 1'b0 : (changed_ff || upd);
      end
      if (ctl.capture) begin
         idx_in = '0;
      end else if (ctl.walk_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      if (ctl.pkt_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.out_node      = req_ff.node;
         rsp_in.out_distance  = '0;
         rsp_in.end_of_table  = 1'b0;
         if (req_ff.node == self_ff) begin
            rsp_in.result_kind   = KIND_DELIVER;
            rsp_in.gate          = '0;
            rsp_in.out_hop_count = req_ff.hop_count;
         end else begin
            rsp_in.result_kind   = KIND_FORWARD;
            rsp_in.gate          = known_hit ? ram_gate : '0;
            rsp_in.out_hop_count = sat_inc(req_ff.hop_count);
         end
      end else if (ctl.walk_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.result_kind   = KIND_TABLE;
         rsp_in.gate          = '0;
         rsp_in.out_node      = NODE_W'(idx_ff);
         rsp_in.out_distance  = (NODE_W'(idx_ff) == self_ff) ? '0 : ram_dist;
         rsp_in.out_hop_count = '0;
         rsp_in.end_of_table  = !stat.scan_more && !stat.extra_self;
      end else if (ctl.self_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.result_kind   = KIND_TABLE;
         rsp_in.gate          = '0;
         rsp_in.out_node      = self_ff;
         rsp_in.out_distance  = '0;
         rsp_in.out_hop_count = '0;
         rsp_in.end_of_table  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff      <= '0;
         known_ff     <= '0;
         changed_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         self_ff      <= self_in;
         known_ff     <= known_in;
         changed_ff   <= changed_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DVR_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, ctl.pkt_load || ctl.walk_load || ctl.self_load, !rsp_valid_ff || !rsp_stall, "result word overwritten while stalled")
   `DVR_ASSERT_NEXT(a_known_grows, clock, reset, 1'b1, (known_ff & $past(known_ff)) == $past(known_ff), "known bit dropped")
   `DVR_ASSERT_NEXT(a_changed_cleared, clock, reset, ctl.entry_commit && stat.entry_adv, !changed_ff, "changed flag kept after table advertisement")

endmodule

### hw/rtl/dvr_ctrl.sv
// Router controller: state machine that sequences entries, packets and table walks.
// Depends on dvr_pkg and the assertion macro header.
`include "distance_vector_router_unit_assert.svh"

module dvr_ctrl import dvr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_command,
   input  status_type stat,
   output ctrl_type   ctl,
   output logic       req_stall
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_ADVERTISE: state_in = ST_WALK_SCAN;
                  CMD_ENTRY:     state_in = ST_ENTRY;
                  CMD_PACKET:    state_in = ST_PACKET;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_ENTRY: begin
            state_in = stat.entry_adv ? ST_WALK_SCAN : ST_IDLE;
         end
         ST_PACKET: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK_SCAN: begin
            if (stat.scan_hit) begin
               state_in = ST_WALK_EMIT;
            end else if (!stat.scan_more) begin
               state_in = stat.extra_self ? ST_WALK_SELF : ST_IDLE;
            end
         end
         ST_WALK_EMIT: begin
            if (stat.out_free) begin
               if (stat.scan_more) begin
                  state_in = ST_WALK_SCAN;
               end else begin
                  state_in = stat.extra_self ? ST_WALK_SELF : ST_IDLE;
               end
            end
         end
         ST_WALK_SELF: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctl.capture = req_valid;
         end
         ST_ENTRY: begin
            ctl.entry_commit = 1'b1;
         end
         ST_PACKET: begin
            ctl.pkt_load = stat.out_free;
         end
         ST_WALK_SCAN: begin
            ctl.walk_read = stat.scan_hit;
            ctl.walk_step = !stat.scan_hit && stat.scan_more;
         end
         ST_WALK_EMIT: begin
            ctl.walk_load = stat.out_free;
            ctl.walk_step = stat.out_free && stat.scan_more;
         end
         ST_WALK_SELF: begin
            ctl.self_load = stat.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DVR_ASSERT_NEXT(a_packet_dispatch, clock, reset, ctl.capture && (req_command == CMD_PACKET), state_ff == ST_PACKET, "packet word not dispatched")
   `DVR_ASSERT_NOW(a_self_tail_needed, clock, reset, state_ff == ST_WALK_SELF, stat.extra_self, "trailing self entry without cause")
   `DVR_ASSERT_NOW(a_step_has_work, clock, reset, ctl.walk_step, stat.scan_more, "walk advanced past the last entry")

endmodule

### hw/rtl/distance_vector_router_unit.sv
// Distance-vector router: a table entry is accepted, then compared and updated; a packet
// is accepted, then its result registered once the output is free. An advertisement
// walks the table one slot a cycle while no entry is found; a found entry is read through
// the single route RAM read port and emitted once the output is free, and an out-of-range
// self follows last. Synchronous reset clears known bits, changed flag, self_node and
// controller; RAM contents stay undefined and are used only behind a known bit.
module distance_vector_router_unit import dvr_pkg::*; #(
   parameter int NODES = 32,
   parameter int GATES = 8
) (
   input  logic              clock,
   input  logic              reset,
   // request channel: one table entry, advertise command or data packet per word
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   // result channel: table entries, deliveries and forwards
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   // self_node register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NODE_W-1:0] csr_data
);

   ctrl_type   ctl;
   status_type stat;

   // Accept register writes at any time; the user, not the block, must let them arrive only while idle.
   assign csr_ready = 1'b1;

   // Sequence each word: dispatch on command, update, then walk when needed.
   dvr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .stat        (stat),
      .ctl         (ctl),
      .req_stall   (req_stall)
   );

   // Hold the route table, the latched word and the result register.
   dvr_datapath #(
      .NODES (NODES),
      .GATES (GATES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
